// ----- rtl/xrr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xrr_pkg: shared definitions for the ranged xorshift generator
// Word width, seeding constants, shift amounts and request codes.
// ----------------------------------------------------------------------------
package xrr_pkg;

    localparam int WORD_W     = 32;
    localparam int WORDS      = 4;
    localparam int CNT_W      = 5;

    localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;

    localparam int SEED_SHIFT = 30;
    localparam int SHIFT_A    = 11;
    localparam int SHIFT_B    = 19;
    localparam int SHIFT_C    = 8;

    localparam logic [1:0] REQ_SEED  = 2'd0;
    localparam logic [1:0] REQ_RAW   = 2'd1;
    localparam logic [1:0] REQ_MOD   = 2'd2;
    localparam logic [1:0] REQ_RANGE = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SEED = 5'b00010,
        ST_STEP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/xorshift_ranged_rng.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xorshift_ranged_rng: xorshift128 generator with range reduction
// Raw words, values modulo (high+1) and values in low..high, with reseeding.
// Requests are taken one at a time; ranged requests with a nonzero modulus
// run the 32-step serial remainder unit, and reseeding runs the seeding
// multiplier once per state word.
// Reset: the seed register returns to 5489 and a seeding pass over the four
// state words runs before the first request is taken.
// ----------------------------------------------------------------------------
module xorshift_ranged_rng
    import xrr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              seed_valid,
    output logic                   seed_ready,
    input  wire logic [WORD_W-1:0] seed_value,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic [1:0]        req_type,
    input  wire logic [WORD_W-1:0] range_low,
    input  wire logic [WORD_W-1:0] range_high,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic [WORD_W-1:0]      random_value,
    output logic                   range_error
);

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(WORD_W - 1);
    localparam logic [CNT_W-1:0] SEED_LAST = CNT_W'(WORDS - 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pend_reg, pend_next;
    logic                use_div_reg, use_div_next;
    logic                err_reg, err_next;
    logic [WORD_W-1:0]   seed_reg, seed_next;
    logic [WORD_W-1:0]   mod_reg, mod_next;
    logic [WORD_W-1:0]   lo_reg, lo_next;
    logic [WORD_W-1:0]   rem_reg, rem_next;
    logic [WORD_W-1:0]   dvd_reg, dvd_next;
    logic [WORD_W-1:0]   words_reg [WORDS];
    logic [WORD_W-1:0]   words_next [WORDS];
    logic                rsp_valid_reg, rsp_valid_next;
    logic [WORD_W-1:0]   value_reg, value_next;
    logic                rerr_reg, rerr_next;

    logic [WORD_W-1:0]   seed_prev;
    logic [WORD_W-1:0]   seed_mix;
    logic [WORD_W-1:0]   mul_prod;
    logic [WORD_W-1:0]   seed_word;
    logic [WORD_W-1:0]   mix_t;
    logic [WORD_W-1:0]   raw_word;
    logic [WORD_W:0]     trial;
    logic                trial_ge;
    logic [WORD_W-1:0]   trial_rem;
    logic [WORD_W-1:0]   mod_plain;
    logic [WORD_W-1:0]   mod_ranged;
    logic                out_free;

    assign seed_prev  = (cnt_reg == '0) ? seed_reg : words_reg[WORDS-1];
    assign seed_mix   = seed_prev ^ (seed_prev >> SEED_SHIFT);
    assign mul_prod   = SEED_MULT * seed_mix;
    assign seed_word  = mul_prod + {{(WORD_W-CNT_W){1'b0}}, cnt_reg};

    assign mix_t      = words_reg[0] ^ (words_reg[0] << SHIFT_A);
    assign raw_word   = (words_reg[WORDS-1] ^ (words_reg[WORDS-1] >> SHIFT_B))
                      ^ (mix_t ^ (mix_t >> SHIFT_C));

    assign trial      = {rem_reg, dvd_reg[WORD_W-1]};
    assign trial_ge   = trial >= {1'b0, mod_reg};
    assign trial_rem  = trial_ge ? WORD_W'(trial - {1'b0, mod_reg}) : trial[WORD_W-1:0];

    assign mod_plain  = range_high + 1'b1;
    assign mod_ranged = range_high - range_low + 1'b1;

    assign out_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        use_div_next   = use_div_reg;
        err_next       = err_reg;
        seed_next      = seed_reg;
        mod_next       = mod_reg;
        lo_next        = lo_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        words_next     = words_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        value_next     = value_reg;
        rerr_next      = rerr_reg;

        if (seed_valid && seed_ready)
        begin
            seed_next = seed_value;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cnt_next     = '0;
                    err_next     = 1'b0;
                    lo_next      = '0;
                    rem_next     = '0;
                    use_div_next = 1'b0;
                    case (req_type)
                        REQ_SEED:
                        begin
                            pend_next  = 1'b1;
                            state_next = ST_SEED;
                        end
                        REQ_RAW:
                        begin
                            state_next = ST_STEP;
                        end
                        REQ_MOD:
                        begin
                            mod_next     = mod_plain;
                            use_div_next = mod_plain != '0;
                            state_next   = ST_STEP;
                        end
                        default:
                        begin
                            if (range_low >= range_high)
                            begin
                                err_next   = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                mod_next     = mod_ranged;
                                lo_next      = range_low;
                                use_div_next = mod_ranged != '0;
                                state_next   = ST_STEP;
                            end
                        end
                    endcase
                end
            end
            ST_SEED:
            begin
                for (int i = 0; i < WORDS - 1; i++)
                begin
                    words_next[i] = words_reg[i+1];
                end
                words_next[WORDS-1] = seed_word;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SEED_LAST)
                begin
                    cnt_next   = '0;
                    state_next = pend_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_STEP:
            begin
                for (int i = 0; i < WORDS - 1; i++)
                begin
                    words_next[i] = words_reg[i+1];
                end
                words_next[WORDS-1] = raw_word;
                dvd_next   = raw_word;
                rem_next   = use_div_reg ? '0 : raw_word;
                cnt_next   = '0;
                state_next = use_div_reg ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                rem_next = trial_rem;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    value_next     = rem_reg + lo_reg;
                    rerr_next      = err_reg;
                    pend_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SEED;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            use_div_reg   <= 1'b0;
            err_reg       <= 1'b0;
            seed_reg      <= SEED_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            use_div_reg   <= use_div_next;
            err_reg       <= err_next;
            seed_reg      <= seed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg   <= mod_next;
        lo_reg    <= lo_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        words_reg <= words_next;
        value_reg <= value_next;
        rerr_reg  <= rerr_next;
    end

    assign seed_ready   = state_reg != ST_SEED;
    assign req_stall    = state_reg != ST_IDLE;
    assign rsp_valid    = rsp_valid_reg;
    assign random_value = value_reg;
    assign range_error  = rerr_reg;

`ifndef SYNTH
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the finish step");

    a_bad_range: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req_type == REQ_RANGE && range_low >= range_high)
        |=> (state_reg == ST_DONE && err_reg))
        else $error("empty range did not go straight to the finish step");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (mod_reg != '0 && use_div_reg))
        else $error("remainder unit running with a zero modulus");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rerr_reg) |-> (value_reg == '0))
        else $error("range error beat carries a nonzero value");
`endif

endmodule
`default_nettype wire
